// ===== rtl/core/gcb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the graph coloring block.
// Used by every module in rtl/core; depends on nothing else.
package gcb_pkg;

   localparam int MAX_VERTICES = 16;
   // Rows carry a 4-bit index, so no more than 16 vertices can ever be in use.
   localparam int VLIMIT       = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int VW           = $clog2(VLIMIT);

   localparam int ROW_W        = 4;
   localparam int ADJ_W        = 16;
   localparam int VERTEX_W     = 4;
   localparam int COLOR_W      = 5;
   localparam int CSET_W       = 1 << COLOR_W;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;

   localparam logic [CSR_DATA_W-1:0] NUM_VERTICES_RST = CSR_DATA_W'(16);
   localparam logic [CSR_DATA_W-1:0] NUM_COLORS_RST   = CSR_DATA_W'(4);
   localparam logic [CSR_DATA_W-1:0] VLIMIT_CNT       = CSR_DATA_W'(VLIMIT);
   localparam logic [VW-1:0]         LAST_VTX_MAX     = VW'(VLIMIT - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_VERTICES = 2'd0,
      CSR_NUM_COLORS   = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic [VW-1:0]      last_vtx;
      logic [COLOR_W-1:0] colors;
   } cfg_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [COLOR_W-1:0]  color;
      logic                found;
      logic                last;
   } res_type;

   // Lowest set bit of a color mask, with a hit flag in the top bit.
   function automatic logic [COLOR_W:0] pick_color(input logic [CSET_W-1:0] avail);
      logic [COLOR_W:0] r;
      r = '0;
      for (int c = CSET_W - 1; c >= 0; c--) begin
         if (avail[c]) begin
            r = {1'b1, COLOR_W'(c)};
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/gcb_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers: vertex count and color count.
// Depends on gcb_pkg.
module gcb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gcb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output gcb_pkg::cfg_type                   cfg
);

   logic [gcb_pkg::CSR_DATA_W-1:0] nv_ff;
   logic [gcb_pkg::CSR_DATA_W-1:0] nc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= gcb_pkg::NUM_VERTICES_RST;
         nc_ff <= gcb_pkg::NUM_COLORS_RST;
      end else if (csr_we) begin
         case (gcb_pkg::csr_reg_type'(csr_index))
            gcb_pkg::CSR_NUM_VERTICES: begin
               nv_ff <= csr_wdata;
            end
            gcb_pkg::CSR_NUM_COLORS: begin
               nc_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // The vertex count is saturated into one to the vertex limit.
   always_comb begin
      if (nv_ff == '0) begin
         cfg.last_vtx = '0;
      end else if (nv_ff > gcb_pkg::VLIMIT_CNT) begin
         cfg.last_vtx = gcb_pkg::LAST_VTX_MAX;
      end else begin
         cfg.last_vtx = gcb_pkg::VW'(nv_ff - gcb_pkg::CSR_DATA_W'(1));
      end
      cfg.colors = nc_ff;
   end

endmodule

// ===== rtl/core/gcb_engine.sv =====
`timescale 1ns / 1ps
// Search engine: adjacency and color memories with the backtracking sequencer.
// Depends on gcb_pkg.
module gcb_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  gcb_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gcb_pkg::ROW_W-1:0]       req_row_index,
   input  logic [gcb_pkg::ADJ_W-1:0]       req_adj_row,
   input  logic                            req_start_solve,
   output logic                            res_push,
   output gcb_pkg::res_type                res,
   input  logic                            res_taken
);

   typedef enum logic [2:0] {
      S_IDLE, S_ROW, S_SCAN, S_DECIDE, S_BACK, S_OREAD, S_OLOAD, S_OWAIT
   } state_type;

   localparam logic [gcb_pkg::ROW_W:0] ROW_CAP = (gcb_pkg::ROW_W + 1)'(gcb_pkg::VLIMIT);

   state_type                          state_ff, state_in;
   logic [gcb_pkg::VW-1:0]             k_ff, k_in;
   logic [gcb_pkg::VW-1:0]             i_ff, i_in;
   logic [gcb_pkg::VW-1:0]             pidx_ff, pidx_in;
   logic                               pend_ff, pend_in;
   logic [gcb_pkg::COLOR_W-1:0]        s_ff, s_in;
   logic [gcb_pkg::CSET_W-1:0]         forb_ff, forb_in;
   logic                               found_ff, found_in;

   logic [gcb_pkg::VLIMIT-1:0]         adj_mem [gcb_pkg::VLIMIT];
   logic [gcb_pkg::VLIMIT-1:0]         adj_q;
   logic [gcb_pkg::COLOR_W-1:0]        col_mem [gcb_pkg::VLIMIT];
   logic [gcb_pkg::COLOR_W-1:0]        col_q;

   logic                               adj_we, adj_re;
   logic                               col_we, col_re;
   logic [gcb_pkg::VW-1:0]             col_raddr;
   logic [gcb_pkg::CSET_W-1:0]         avail;
   logic [gcb_pkg::COLOR_W:0]          pick;
   logic                               accept;
   logic                               row_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign row_ok    = ({1'b0, req_row_index} < ROW_CAP);

   // Adjacency memory: written only while idle, read once per vertex visit.
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[req_row_index[gcb_pkg::VW-1:0]] <= req_adj_row[gcb_pkg::VLIMIT-1:0];
      end
      if (adj_re) begin
         adj_q <= adj_mem[k_ff];
      end
   end

   // Color memory. A write and a read of the same entry never fall in the
   // same cycle, so no forwarding path is needed.
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[k_ff] <= pick[gcb_pkg::COLOR_W-1:0];
      end
      if (col_re) begin
         col_q <= col_mem[col_raddr];
      end
   end

   always_comb begin
      for (int c = 0; c < gcb_pkg::CSET_W; c++) begin
         avail[c] = (gcb_pkg::COLOR_W'(c) > s_ff) && (gcb_pkg::COLOR_W'(c) <= cfg.colors)
                    && !forb_ff[c];
      end
      pick = gcb_pkg::pick_color(avail);
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      pidx_in   = pidx_ff;
      pend_in   = pend_ff;
      s_in      = s_ff;
      forb_in   = forb_ff;
      found_in  = found_ff;
      adj_we    = 1'b0;
      adj_re    = 1'b0;
      col_we    = 1'b0;
      col_re    = 1'b0;
      col_raddr = i_ff;
      res_push  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               adj_we = row_ok;
               if (req_start_solve) begin
                  k_in     = '0;
                  s_in     = '0;
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            adj_re  = 1'b1;
            forb_in = '0;
            if (k_ff != '0) begin
               col_re    = 1'b1;
               col_raddr = '0;
               pend_in   = 1'b1;
               pidx_in   = '0;
               i_in      = gcb_pkg::VW'(1);
            end else begin
               pend_in = 1'b0;
               i_in    = '0;
            end
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (pend_ff && adj_q[pidx_ff]) begin
               forb_in = forb_ff | (gcb_pkg::CSET_W'(1) << col_q);
            end
            if (i_ff != k_ff) begin
               col_re    = 1'b1;
               col_raddr = i_ff;
               pend_in   = 1'b1;
               pidx_in   = i_ff;
               i_in      = i_ff + gcb_pkg::VW'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (pick[gcb_pkg::COLOR_W]) begin
               col_we = 1'b1;
               if (k_ff == cfg.last_vtx) begin
                  found_in = 1'b1;
                  k_in     = '0;
                  state_in = S_OREAD;
               end else begin
                  k_in     = k_ff + gcb_pkg::VW'(1);
                  s_in     = '0;
                  state_in = S_ROW;
               end
            end else if (k_ff == '0) begin
               found_in = 1'b0;
               state_in = S_OREAD;
            end else begin
               k_in      = k_ff - gcb_pkg::VW'(1);
               col_re    = 1'b1;
               col_raddr = k_ff - gcb_pkg::VW'(1);
               state_in  = S_BACK;
            end
         end
         S_BACK: begin
            s_in     = col_q;
            state_in = S_ROW;
         end
         S_OREAD: begin
            col_re    = 1'b1;
            col_raddr = k_ff;
            state_in  = S_OLOAD;
         end
         S_OLOAD: begin
            res_push = 1'b1;
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            if (res_taken) begin
               if (k_ff == cfg.last_vtx) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + gcb_pkg::VW'(1);
                  state_in = S_OREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res.vertex = gcb_pkg::VERTEX_W'(k_ff);
      res.color  = found_ff ? col_q : '0;
      res.found  = found_ff;
      res.last   = (k_ff == cfg.last_vtx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
      k_ff    <= k_in;
      i_ff    <= i_in;
      pidx_ff <= pidx_in;
      s_ff    <= s_in;
      forb_ff <= forb_in;
   end

endmodule

// ===== rtl/core/graph_coloring_backtrack.sv =====
`timescale 1ns / 1ps
// Top level of the graph coloring block: configuration, search engine and
// result register. Depends on gcb_pkg, gcb_csr and gcb_engine.
//
// Usage. Each req_ item carries one row of the adjacency matrix; bit j of
// req_adj_row set means vertex req_row_index is adjacent to vertex j. While
// the block is idle, rows may follow back to back. The item with
// req_start_solve set is stored like any other row and then starts the search.
// While the search and the result drain run, req_stall stays high.
// The csr_ port sets num_vertices (index 0) and num_colors (index 1); it is
// always ready and must be written only while the block is idle.
// The search visits vertices in index order. A visit of vertex k reads its
// adjacency row, scans the colors of all earlier vertices one per cycle
// through the single read port of the color memory and then picks a color;
// a step back to a vertex first reloads its color. The worst case therefore
// grows with the number of backtracking steps, which depends on the graph.
// After the search, one rsp_ item per vertex follows, vertex 0 first, each
// read only after the previous one has been taken; rsp_last marks the
// final vertex. On failure every item has color 0 and found 0. A stall on rsp_
// holds the item in the result register and pauses the drain.
// Reset (synchronous, active high) returns the block to idle and restores the
// register defaults of 16 vertices and 4 colors; adjacency rows are not cleared.
module graph_coloring_backtrack (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gcb_pkg::ROW_W-1:0]       req_row_index,
   input  logic [gcb_pkg::ADJ_W-1:0]       req_adj_row,
   input  logic                            req_start_solve,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gcb_pkg::VERTEX_W-1:0]    rsp_vertex,
   output logic [gcb_pkg::COLOR_W-1:0]     rsp_color,
   output logic                            rsp_found,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gcb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gcb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   gcb_pkg::cfg_type cfg;
   gcb_pkg::res_type res;
   gcb_pkg::res_type res_ff;
   logic             res_push;
   logic             res_taken;
   logic             rsp_valid_ff;

   // The registers can always take a write, so the port never pushes back.
   assign csr_ready = 1'b1;

   gcb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcb_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row_index   (req_row_index),
      .req_adj_row     (req_adj_row),
      .req_start_solve (req_start_solve),
      .res_push        (res_push),
      .res             (res),
      .res_taken       (res_taken)
   );

   // Result register. The engine pushes a new item only after the previous
   // one has been taken, so a push never meets a full register.
   assign res_taken = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (res_taken) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_push) begin
         res_ff <= res;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = res_ff.vertex;
   assign rsp_color  = res_ff.color;
   assign rsp_found  = res_ff.found;
   assign rsp_last   = res_ff.last;

endmodule

// ===== rtl/core/gcb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the graph coloring block, bound to the top level.
// Depends on gcb_pkg and graph_coloring_backtrack.
module gcb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_start_solve,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [gcb_pkg::VERTEX_W-1:0]    rsp_vertex,
   input logic [gcb_pkg::COLOR_W-1:0]     rsp_color,
   input logic                            rsp_found,
   input logic                            rsp_last
);

   // A row that starts the search closes the input side.
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_start_solve) |=> req_stall)
      else $error("input not stalled after a search was started");

   // No row is taken while results are still being delivered.
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result item is pending");

   // A failed search reports color 0; a successful one never does.
   a_color_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_found && rsp_color != '0) || (!rsp_found && rsp_color == '0)))
      else $error("result color disagrees with the found flag");

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_vertex) && $stable(rsp_color)
                                    && $stable(rsp_found) && $stable(rsp_last)))
      else $error("stalled result item changed");

endmodule

bind graph_coloring_backtrack gcb_checker u_gcb_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for graph_coloring_backtrack: loads adjacency rows, runs
// searches under several register settings and checks every color report item.
// Depends on gcb_pkg and the RTL in rtl/core; it reads no files at run time.
module tb;

   localparam int RESET_CYCLES   = 12;
   // Estimated search cycles allowed for one random graph; costlier graphs are redrawn.
   localparam int SEARCH_BUDGET  = 4000;
   // Quiet cycles allowed after the last result before a register write or the end.
   localparam int SETTLE_CYCLES  = 16;
   // Length of the long receiver hold-off that backs the block up.
   localparam int HOLD_CYCLES    = 600;
   // Cycles without any accepted item before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 60000;
   localparam logic [gcb_pkg::ADJ_W-1:0] ALL_ADJ = {gcb_pkg::ADJ_W{1'b1}};

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [gcb_pkg::ROW_W-1:0]      req_row_index = '0;
   logic [gcb_pkg::ADJ_W-1:0]      req_adj_row = '0;
   logic                           req_start_solve = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [gcb_pkg::VERTEX_W-1:0]   rsp_vertex;
   logic [gcb_pkg::COLOR_W-1:0]    rsp_color;
   logic                           rsp_found;
   logic                           rsp_last;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [gcb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gcb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   graph_coloring_backtrack dut (.*);

   // Mirror of the block: stored rows, register values and the color reports still due.
   logic [gcb_pkg::ADJ_W-1:0]   adj_image   [gcb_pkg::VLIMIT];
   logic [gcb_pkg::ADJ_W-1:0]   graph_rows  [gcb_pkg::VLIMIT];
   logic [gcb_pkg::COLOR_W-1:0] graph_color [gcb_pkg::VLIMIT];
   int                          cfg_vertices = 16;
   int                          cfg_colors   = 4;
   gcb_pkg::res_type            coloring_q [$];
   gcb_pkg::res_type            due;

   // Idle rates in percent for the sender and the receiver.
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   // The stimulus asks for a long hold-off by bumping holds_asked; the receiver counts it out.
   int holds_asked   = 0;
   int holds_granted = 0;
   int hold_left     = 0;

   int mismatches      = 0;
   int rows_loaded     = 0;
   int searches        = 0;
   int unsolved        = 0;
   int results_checked = 0;
   int config_writes   = 0;
   int worst_cost      = 0;
   int quiet_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Coloring predictor
   // ---------------------------------------------------------------------------------------

   // The vertex register is saturated into 1..VLIMIT before a search.
   function automatic int active_vertices();
      if (cfg_vertices < 1) return 1;
      if (cfg_vertices > gcb_pkg::VLIMIT) return gcb_pkg::VLIMIT;
      return cfg_vertices;
   endfunction

   // Vertex k only looks at lower-numbered vertices, through bit i of its own row, so an
   // asymmetric matrix is honored exactly as stored.
   function automatic bit color_taken(input int k, input int c);
      for (int i = 0; i < k; i++) begin
         if (graph_rows[k][i] && graph_color[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Depth-first backtracking over graph_rows. Returns the block's search cycles, counted
   // per vertex visit and per step back, or -1 once the budget is exceeded, so the
   // stimulus can steer clear of long searches.
   function automatic int color_search(input int n, input int m, input int budget,
                                       output bit solved);
      int cur;
      int c;
      int cost;
      cur = 0;
      cost = 0;
      solved = 1'b0;
      for (int i = 0; i < gcb_pkg::VLIMIT; i++) graph_color[i] = '0;
      while (cost <= budget) begin
         cost += (cur == 0) ? 3 : cur + 2;
         c = graph_color[cur] + 1;
         while (c <= m && color_taken(cur, c)) c++;
         if (c <= m) begin
            graph_color[cur] = c[gcb_pkg::COLOR_W-1:0];
            if (cur == n - 1) begin
               solved = 1'b1;
               return cost;
            end
            cur++;
         end else begin
            // Out of colors: clear this vertex and retry the previous one.
            graph_color[cur] = '0;
            if (cur == 0) return cost;
            cur--;
            cost += 1;
         end
      end
      return -1;
   endfunction

   // Runs the search on the stored rows and queues one report per vertex in use.
   function automatic void predict_colors();
      gcb_pkg::res_type r;
      int               n;
      int               cost;
      bit               solved;
      n = active_vertices();
      graph_rows = adj_image;
      cost = color_search(n, cfg_colors, 1 << 30, solved);
      searches++;
      if (!solved) unsolved++;
      if (cost > worst_cost) worst_cost = cost;
      for (int v = 0; v < n; v++) begin
         r.vertex = gcb_pkg::VERTEX_W'(v);
         r.color  = solved ? graph_color[v] : '0;
         r.found  = solved;
         r.last   = (v == n - 1);
         coloring_q.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------

   // Offers one row item. Valid stays high after acceptance so that a following item can go
   // out back to back; whoever stops sending lowers it, in a later time step.
   task automatic load_row(input logic [gcb_pkg::ROW_W-1:0] idx,
                           input logic [gcb_pkg::ADJ_W-1:0] bits, input bit go);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_row_index   <= idx;
      req_adj_row     <= bits;
      req_start_solve <= go;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      adj_image[idx] = bits;
      rows_loaded++;
      if (go) predict_colors();
   endtask

   // Stops sending, waits for every due report, then lets the block come to rest.
   task automatic settle();
      req_valid <= 1'b0;
      while (coloring_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back while the block is idle.
   task automatic write_config(input int vertices, input int colors);
      settle();
      csr_valid <= 1'b1;
      csr_index <= gcb_pkg::CSR_NUM_VERTICES;
      csr_wdata <= gcb_pkg::CSR_DATA_W'(vertices);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_vertices = vertices & 31;
      csr_index <= gcb_pkg::CSR_NUM_COLORS;
      csr_wdata <= gcb_pkg::CSR_DATA_W'(colors);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_colors = colors & 31;
      csr_valid <= 1'b0;
      config_writes += 2;
   endtask

   // Register value picker: half the time a typical range, otherwise an extreme or any value.
   function automatic int pick_setting(input int lo, input int hi);
      case ($urandom_range(9))
         0:       return 0;
         1:       return 1;
         2:       return 16;
         3:       return 31;
         4:       return $urandom_range(31);
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic logic [gcb_pkg::ADJ_W-1:0] random_row(input int density);
      logic [gcb_pkg::ADJ_W-1:0] r;
      if (density < 0) return gcb_pkg::ADJ_W'($urandom);
      for (int b = 0; b < gcb_pkg::ADJ_W; b++) r[b] = ($urandom_range(99) < density);
      return r;
   endfunction

   // A well-formed graph rewrites every row in use, in shuffled order, and solves on the
   // last one. A broken sequence rewrites one to three random rows and solves only
   // sometimes, so the search also runs on a mix of old and new rows.
   task automatic random_graph(input bit wellformed);
      logic [gcb_pkg::ROW_W-1:0] order [gcb_pkg::VLIMIT];
      logic [gcb_pkg::ROW_W-1:0] tmp;
      int                        n;
      int                        density;
      int                        tries;
      int                        cost;
      int                        pick;
      int                        count;
      bit                        solved;
      bit                        go;
      n = active_vertices();
      if (wellformed) begin
         tries = 0;
         cost = -1;
         while (cost < 0 && tries < 20) begin
            graph_rows = adj_image;
            case ($urandom_range(5))
               0:       density = 0;
               1:       density = 15;
               2:       density = 35;
               3:       density = 60;
               4:       density = 100;
               default: density = -1;
            endcase
            for (int k = 0; k < n; k++) graph_rows[k] = random_row(density);
            if ($urandom_range(1)) begin
               // Make the upper triangle match the lower one, as for an undirected graph.
               for (int k = 0; k < n; k++) begin
                  for (int i = 0; i < k; i++) graph_rows[i][k] = graph_rows[k][i];
               end
            end
            cost = color_search(n, cfg_colors, SEARCH_BUDGET, solved);
            tries++;
         end
         // If every draw searched too long, an empty graph always finishes quickly.
         if (cost < 0) begin
            for (int k = 0; k < n; k++) graph_rows[k] = '0;
         end
         for (int k = 0; k < n; k++) order[k] = gcb_pkg::ROW_W'(k);
         for (int k = n - 1; k > 0; k--) begin
            pick = $urandom_range(k);
            tmp = order[k];
            order[k] = order[pick];
            order[pick] = tmp;
         end
         for (int k = 0; k < n; k++) load_row(order[k], graph_rows[order[k]], k == n - 1);
      end else begin
         count = $urandom_range(1, 3);
         graph_rows = adj_image;
         for (int j = 0; j < count; j++) begin
            order[j] = gcb_pkg::ROW_W'($urandom_range(gcb_pkg::VLIMIT - 1));
            graph_rows[order[j]] = random_row(-1);
         end
         go = 1'b0;
         if ($urandom_range(3) != 0) begin
            go = color_search(n, cfg_colors, SEARCH_BUDGET, solved) >= 0;
         end
         for (int j = 0; j < count; j++) begin
            load_row(order[j], graph_rows[order[j]], go && j == count - 1);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset registers (16 vertices, 4 colors): a clique on vertices 0..3 and isolated
   // vertices above it. This also writes every row once, so no search reads an unwritten one.
   task automatic test_reset_defaults();
      for (int k = 0; k < gcb_pkg::VLIMIT; k++) begin
         load_row(gcb_pkg::ROW_W'(k), (k < 4) ? ALL_ADJ : '0, k == gcb_pkg::VLIMIT - 1);
      end
   endtask

   // Register values above range: the vertex count saturates to 16 and a color count of 31
   // is used as is. The top vertex touches all others and needs a fifth color.
   task automatic test_register_limits();
      write_config(31, 31);
      load_row(gcb_pkg::ROW_W'(gcb_pkg::VLIMIT - 1), ALL_ADJ, 1'b1);
   endtask

   // A vertex count of zero saturates to one vertex, and zero colors leave it uncolored.
   task automatic test_zero_settings();
      write_config(0, 0);
      load_row('0, '0, 1'b1);
   endtask

   // Row 0 claims an edge to vertex 1, but vertex 1 only reads its own row, which has bit 0
   // clear, so a single color suffices.
   task automatic test_asymmetric_rows();
      write_config(2, 1);
      load_row(gcb_pkg::ROW_W'(0), 16'h0002, 1'b0);
      load_row(gcb_pkg::ROW_W'(1), 16'hFFFE, 1'b1);
   endtask

   // Edges 0-2, 1-3 and 2-3 with two colors: the first choice for vertex 1 dead-ends at
   // vertex 3, and the search has to step back twice. With one color the same graph fails
   // after backing all the way out to vertex 0.
   task automatic test_backtracking();
      write_config(4, 2);
      load_row(gcb_pkg::ROW_W'(0), 16'h0004, 1'b0);
      load_row(gcb_pkg::ROW_W'(1), 16'h0008, 1'b0);
      load_row(gcb_pkg::ROW_W'(2), 16'h0009, 1'b0);
      load_row(gcb_pkg::ROW_W'(3), 16'h0006, 1'b1);
      write_config(4, 1);
      load_row(gcb_pkg::ROW_W'(3), 16'h0006, 1'b1);
   endtask

   // Full 16-vertex clique with 16 colors, which reaches the largest color. The receiver
   // holds off for a long stretch, so the reports back up and the rows that follow wait
   // at a stalled input.
   task automatic test_backpressure();
      write_config(16, 16);
      holds_asked <= holds_asked + 1;
      for (int k = 0; k < gcb_pkg::VLIMIT; k++) begin
         load_row(gcb_pkg::ROW_W'(k), ALL_ADJ, k == gcb_pkg::VLIMIT - 1);
      end
      for (int j = 0; j < 3; j++) begin
         load_row(gcb_pkg::ROW_W'($urandom_range(gcb_pkg::VLIMIT - 1)),
                  gcb_pkg::ADJ_W'($urandom), 1'b0);
      end
   endtask

   task automatic test_random_graphs(input int item_goal);
      int goal;
      goal = rows_loaded + item_goal;
      while (rows_loaded < goal) begin
         if ($urandom_range(3) == 0) write_config(pick_setting(2, 8), pick_setting(2, 4));
         random_graph($urandom_range(4) != 0);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------------------------------

   // Random stall at the current rate, or the long hold-off when one has been asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         rsp_stall     <= 1'b1;
         hold_left     <= HOLD_CYCLES - 1;
         holds_granted <= holds_granted + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Every accepted report item is matched against the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (coloring_q.size() == 0) begin
            $error("report for vertex %0d arrived with no search pending", rsp_vertex);
            mismatches++;
         end else begin
            due = coloring_q.pop_front();
            check_field("vertex", due.vertex, rsp_vertex);
            check_field("color", due.color, rsp_color);
            check_field("found", due.found, rsp_found);
            check_field("last", due.last, rsp_last);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      // Sender idles often, receiver stalls more often still.
      send_gap_pct  = 31;
      rsp_stall_pct = 59;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_limits();
      test_zero_settings();
      test_asymmetric_rows();
      test_backtracking();
      test_random_graphs(30);

      // The other way round: the sender is the slow side.
      send_gap_pct  = 59;
      rsp_stall_pct = 31;
      test_random_graphs(30);

      // Neither side idles, apart from the one long hold-off.
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_backpressure();
      test_random_graphs(30);

      settle();
      $display("Loaded %0d rows and ran %0d searches (%0d without a coloring); %0d reports checked.",
               rows_loaded, searches, unsolved, results_checked);
      $display("Register writes: %0d; costliest search about %0d cycles.",
               config_writes, worst_cost);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
